[hw/rtl/awf_pkg.sv]
`timescale 1ns / 1ps

package awf_pkg;

   localparam int unsigned SAMPLE_BITS_DEFAULT     = 24;
   localparam int unsigned SINE_TABLE_BITS_DEFAULT = 10;

   // configuration port
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLE         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FOLD_TYPE      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SINE_DRIVE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIANGLE_DRIVE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INPUT_GAIN     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_GAIN    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WET_MIX        = 3'd6;

   localparam int unsigned GAIN_BITS = 16;
   localparam int unsigned MIX_BITS  = 13;

   // Q4.12 unity and Q1.12 full wet
   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd4096;
   localparam logic [MIX_BITS-1:0]  WET_FULL   = 13'd4096;

   // all gains are Q4.12: round half up by 12 bits
   localparam int unsigned ROUND_BITS = 12;
   localparam int unsigned ROUND_HALF = 2048;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // One entry of the full-cycle sine table with sb-1 fraction bits.
   // Quarter wave by a Q30 Taylor series of degree 17, mirrored by symmetry.
   function automatic logic [63:0] sine_entry(input int unsigned k, input int unsigned sb,
                                              input int unsigned tb);
      logic [63:0]        qmax;
      logic [63:0]        kk;
      logic [63:0]        quad;
      logic [63:0]        r;
      logic [63:0]        q;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] val;
      logic signed [63:0] maxv;
      int unsigned        s;
      qmax = 64'd1 << (tb - 2);
      kk   = 64'(k) & ((64'd1 << tb) - 64'd1);
      quad = kk >> (tb - 2);
      r    = kk & (qmax - 64'd1);
      q    = quad[0] ? (qmax - r) : r;
      x    = (HALF_PI_Q30 * q + (qmax >> 1)) >> (tb - 2);
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            7: term = term / 64'd210;
            default: term = term / 64'd272;
         endcase
         if (n % 2 == 1) sum = sum - $signed(term);
         else            sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      s = sb - 1;
      if (s >= 30) val = sum <<< ((s - 30) & 7);
      else         val = (sum + (64'sd1 <<< (29 - s))) >>> (30 - s);
      maxv = (64'sd1 <<< s) - 64'sd1;
      if (val > maxv) val = maxv;
      if (quad[1]) val = -val;
      return val;
   endfunction

endpackage

[hw/rtl/audio_wavefolder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_sample_in  (signed Q1.(SAMPLE_BITS-1))
// rsp       out        rsp_valid/rsp_ready   rsp_sample_out (signed Q1.(SAMPLE_BITS-1))
// csr       in         csr_valid/csr_ready   csr_index, csr_data (register write)
//
// Thirteen register stages: one sample per clock is sustained while the output is not
// stalled; the gain, fold, mix and output multipliers each own a stage, and the sine
// table is read into stage 6.
// Reset clears every stage valid bit and loads the register defaults (bypass,
// sine fold, unity gains and drives, fully wet). The sine table is a constant ROM.
// Each stage holds its valid bit; a full stage holds while the stage after it
// cannot take its item, so a stalled output fills the pipe behind it, bubbles close up,
// and nothing is lost or repeated.
module audio_wavefolder import awf_pkg::*; #(
   parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEFAULT,
   parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int SB  = SAMPLE_BITS;
   localparam int TB  = SINE_TABLE_BITS;
   localparam int TBL = 1 << TB;
   localparam int NST = 13;

   localparam int GPW = SB + 17;               // sample times input gain
   localparam int GW  = SB + 5;                // gained sample g
   localparam int PW  = SB + 13;               // fold phase
   localparam int LOW = SB + 12 - TB;          // phase bits below the table index
   localparam int FB  = (LOW > 16) ? 16 : LOW; // interpolation fraction bits
   localparam int WW  = SB + 1;                // folded value w
   localparam int DW  = SB + 1;                // table step
   localparam int IPW = DW + FB + 1;           // step times fraction
   localparam int MXW = SB + 20;               // mix products
   localparam int YW  = SB + 8;                // mixed value y
   localparam int OPW = SB + 25;               // y times output gain
   localparam int OW  = SB + 13;               // unsaturated output

   localparam logic [PW-1:0] TRI_OFFSET = PW'(64'd1 << (SB + 11));
   localparam logic [PW:0]   TRI_BIAS   = (PW + 1)'((64'd1 << (SB + 11)) - 64'(ROUND_HALF));

   // ---------------------------------------------------------------- configuration
   logic                 enable_ff;
   logic                 fold_type_ff;
   logic [GAIN_BITS-1:0] sine_drive_ff;
   logic [GAIN_BITS-1:0] triangle_drive_ff;
   logic [GAIN_BITS-1:0] input_gain_ff;
   logic [GAIN_BITS-1:0] output_gain_ff;
   logic [MIX_BITS-1:0]  wet_mix_ff;

   // writes land at once; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         fold_type_ff      <= 1'b0;
         sine_drive_ff     <= GAIN_UNITY;
         triangle_drive_ff <= GAIN_UNITY;
         input_gain_ff     <= GAIN_UNITY;
         output_gain_ff    <= GAIN_UNITY;
         wet_mix_ff        <= WET_FULL;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ENABLE:         enable_ff         <= csr_data[0];
            REG_FOLD_TYPE:      fold_type_ff      <= csr_data[0];
            REG_SINE_DRIVE:     sine_drive_ff     <= csr_data[GAIN_BITS-1:0];
            REG_TRIANGLE_DRIVE: triangle_drive_ff <= csr_data[GAIN_BITS-1:0];
            REG_INPUT_GAIN:     input_gain_ff     <= csr_data[GAIN_BITS-1:0];
            REG_OUTPUT_GAIN:    output_gain_ff    <= csr_data[GAIN_BITS-1:0];
            REG_WET_MIX:        wet_mix_ff        <= csr_data[MIX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- sine table
   logic signed [SB-1:0] sine_rom [TBL];

   for (genvar k = 0; k < TBL; k++) begin : g_rom
      localparam logic [63:0] ENTRY = sine_entry(k, SB, TB);
      assign sine_rom[k] = ENTRY[SB-1:0];
   end

   // ---------------------------------------------------------------- stage control
   // A stage takes a new item when it is empty or its item moves on this cycle.
   logic [NST+1:1] rdy;
   logic [NST:1]   vld_ff;
   logic [NST:1]   vld_in;

   assign rdy[NST+1] = rsp_ready;
   for (genvar k = 1; k <= NST; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign vld_in = (rdy[NST:1] & {vld_ff[NST-1:1], req_valid}) | (~rdy[NST:1] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[1];
   assign rsp_valid = vld_ff[NST];

   // ---------------------------------------------------------------- datapath
   logic signed [SB-1:0]  raw_ff [1:NST-1];   // dry sample, kept for bypass
   logic signed [GPW-1:0] pg_ff;
   logic signed [GPW-1:0] pg_in;
   logic [GPW-1:0]        pg_rnd;
   logic signed [GW-1:0]  g_ff [3:9];
   logic [PW-1:0]         ph_ff;
   logic [PW-1:0]         ph_in;
   logic [GAIN_BITS-1:0]  drive;
   logic [TB-1:0]         idx_ff;
   logic [TB-1:0]         idx1_ff;
   logic [FB-1:0]         frac_ff [5:7];
   logic [PW-1:0]         m_ff;
   logic signed [SB-1:0]  e0_ff [6:8];
   logic signed [SB-1:0]  e1_ff;
   logic [PW-1:0]         a_ff;
   logic [PW:0]           m_neg;
   logic [PW-1:0]         a_in;
   logic signed [DW-1:0]  diff_ff;
   logic [PW:0]           tri_sum;
   logic signed [WW-1:0]  wt_ff [7:8];
   logic signed [IPW-1:0] ip_ff;
   logic signed [IPW-1:0] ip_in;
   logic [IPW-1:0]        ip_rnd;
   logic [SB+1:0]         w_sum;
   logic signed [WW-1:0]  w_ff;
   logic signed [WW-1:0]  w_in;
   logic [MIX_BITS-1:0]   wet;
   logic [MIX_BITS-1:0]   dry;
   logic signed [MXW-1:0] mw_ff;
   logic signed [MXW-1:0] mg_ff;
   logic signed [MXW-1:0] mw_in;
   logic signed [MXW-1:0] mg_in;
   logic [MXW-1:0]        y_sum;
   logic signed [YW-1:0]  y_ff;
   logic signed [OPW-1:0] po_ff;
   logic signed [OPW-1:0] po_in;
   logic [OPW-1:0]        o_rnd;
   logic [OW-1:0]         o_val;
   logic [SB-1:0]         o_sat;
   logic signed [SB-1:0]  out_ff;
   logic signed [SB-1:0]  out_in;

   // dry sample line
   always_ff @(posedge clock) begin
      if (rdy[1]) raw_ff[1] <= req_sample_in;
      for (int k = 2; k <= NST - 1; k++) begin
         if (rdy[k]) raw_ff[k] <= raw_ff[k-1];
      end
   end

   // stage 2: input gain product
   assign pg_in = $signed({{17{raw_ff[1][SB-1]}}, raw_ff[1]})
                * $signed({{(SB + 1){1'b0}}, input_gain_ff});

   always_ff @(posedge clock) begin
      if (rdy[2]) pg_ff <= pg_in;
   end

   // stage 3: round to g
   assign pg_rnd = pg_ff + GPW'(ROUND_HALF);

   always_ff @(posedge clock) begin
      if (rdy[3]) g_ff[3] <= pg_rnd[GPW-1:ROUND_BITS];
      for (int k = 4; k <= 9; k++) begin
         if (rdy[k]) g_ff[k] <= g_ff[k-1];
      end
   end

   // stage 4: fold phase, only its low bits matter
   assign drive = fold_type_ff ? triangle_drive_ff : sine_drive_ff;
   assign ph_in = {{(PW - GW){g_ff[3][GW-1]}}, g_ff[3]} * {{(PW - GAIN_BITS){1'b0}}, drive};

   always_ff @(posedge clock) begin
      if (rdy[4]) ph_ff <= ph_in;
   end

   // stage 5: split the sine phase, shift the triangle phase by a quarter
   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         idx_ff     <= ph_ff[SB+11 -: TB];
         idx1_ff    <= ph_ff[SB+11 -: TB] + TB'(1);
         frac_ff[5] <= ph_ff[LOW-1 -: FB];
         m_ff       <= ph_ff + TRI_OFFSET;
      end
   end

   // stage 6: table read; triangle distance to the nearest whole cycle
   assign m_neg = {1'b1, {PW{1'b0}}} - {1'b0, m_ff};
   assign a_in  = ({1'b0, m_ff} < m_neg) ? m_ff : m_neg[PW-1:0];

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         e0_ff[6]   <= sine_rom[idx_ff];
         e1_ff      <= sine_rom[idx1_ff];
         frac_ff[6] <= frac_ff[5];
         a_ff       <= a_in;
      end
   end

   // stage 7: table step; triangle output
   assign tri_sum = {1'b0, a_ff} - TRI_BIAS;

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         diff_ff    <= {e1_ff[SB-1], e1_ff} - {e0_ff[6][SB-1], e0_ff[6]};
         e0_ff[7]   <= e0_ff[6];
         frac_ff[7] <= frac_ff[6];
         wt_ff[7]   <= tri_sum[SB+12:ROUND_BITS];
      end
   end

   // stage 8: interpolation product
   assign ip_in = $signed({{(IPW - DW){diff_ff[DW-1]}}, diff_ff})
                * $signed({{(IPW - FB){1'b0}}, frac_ff[7]});

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         ip_ff    <= ip_in;
         e0_ff[8] <= e0_ff[7];
         wt_ff[8] <= wt_ff[7];
      end
   end

   // stage 9: folded value
   assign ip_rnd = ip_ff + IPW'(64'd1 << (FB - 1));
   assign w_sum  = {{2{e0_ff[8][SB-1]}}, e0_ff[8]} + ip_rnd[IPW-1:FB];
   assign w_in   = fold_type_ff ? wt_ff[8] : w_sum[WW-1:0];

   always_ff @(posedge clock) begin
      if (rdy[9]) w_ff <= w_in;
   end

   // stage 10: wet and dry products; mix above full acts as full
   assign wet   = (wet_mix_ff > WET_FULL) ? WET_FULL : wet_mix_ff;
   assign dry   = WET_FULL - wet;
   assign mw_in = $signed({{(MXW - WW){w_ff[WW-1]}}, w_ff})
                * $signed({{(MXW - MIX_BITS){1'b0}}, wet});
   assign mg_in = $signed({{(MXW - GW){g_ff[9][GW-1]}}, g_ff[9]})
                * $signed({{(MXW - MIX_BITS){1'b0}}, dry});

   always_ff @(posedge clock) begin
      if (rdy[10]) begin
         mw_ff <= mw_in;
         mg_ff <= mg_in;
      end
   end

   // stage 11: blend and round
   assign y_sum = mw_ff + mg_ff + MXW'(ROUND_HALF);

   always_ff @(posedge clock) begin
      if (rdy[11]) y_ff <= y_sum[MXW-1:ROUND_BITS];
   end

   // stage 12: output gain product
   assign po_in = $signed({{(OPW - YW){y_ff[YW-1]}}, y_ff})
                * $signed({{(OPW - GAIN_BITS){1'b0}}, output_gain_ff});

   always_ff @(posedge clock) begin
      if (rdy[12]) po_ff <= po_in;
   end

   // stage 13: round, saturate, pick bypass; this is the output register
   assign o_rnd = po_ff + OPW'(ROUND_HALF);
   assign o_val = o_rnd[OPW-1:ROUND_BITS];

   always_comb begin
      if (o_val[OW-1:SB-1] == {(OW - SB + 1){o_val[OW-1]}}) begin
         o_sat = o_val[SB-1:0];
      end else if (o_val[OW-1]) begin
         o_sat = {1'b1, {(SB - 1){1'b0}}};
      end else begin
         o_sat = {1'b0, {(SB - 1){1'b1}}};
      end
   end

   assign out_in = enable_ff ? o_sat : raw_ff[NST-1];

   always_ff @(posedge clock) begin
      if (rdy[13]) out_ff <= out_in;
   end

   assign rsp_sample_out = out_ff;

endmodule

[tb/audio_wavefolder_tb.sv]
`timescale 1ns / 1ps

module audio_wavefolder_tb;
   import awf_pkg::*;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int LUT_BITS    = 10;
   localparam int LUT_SIZE    = 1 << LUT_BITS;
   localparam int QUARTER     = LUT_SIZE / 4;
   localparam int GAIN_FRAC   = 12;
   // fold phase in cycles carries the sample fraction plus the Q4.12 drive fraction, plus one
   localparam int PHASE_BITS   = SAMPLE_BITS + GAIN_FRAC;
   localparam int LUT_LOW      = PHASE_BITS - LUT_BITS;
   localparam int INTERP_SHIFT = (LUT_LOW > 16) ? LUT_LOW - 16 : 0;
   localparam int INTERP_BITS  = LUT_LOW - INTERP_SHIFT;
   localparam int LATENCY      = 13;
   localparam int WATCHDOG_NS  = 5_000_000;

   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam longint TRI_BIAS    = 64'sd1 <<< (FRAC_BITS + GAIN_FRAC);
   localparam longint TRI_PERIOD  = 64'sd1 <<< (FRAC_BITS + GAIN_FRAC + 2);
   localparam longint WET_UNITY   = 4096;
   localparam longint GAIN_ONE    = 4096;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

   localparam logic FOLD_SINE     = 1'b0;
   localparam logic FOLD_TRIANGLE = 1'b1;
   // index with no register behind it: writes must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic signed [SAMPLE_BITS-1:0] sample_out;
   } folded_sample_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_data;

   // shadow copy of the register file, updated on each csr transfer
   longint cfg_enable;
   longint cfg_fold;
   longint cfg_sine_drive;
   longint cfg_tri_drive;
   longint cfg_in_gain;
   longint cfg_out_gain;
   longint cfg_wet;

   longint            sine_lut [0:LUT_SIZE];
   folded_sample_type pending_samples[$];
   folded_sample_type oldest;
   int                error_count;

   // idling controls shared between the stimulus and the ready generator
   bit sender_idle_on;
   bit receiver_idle_on;
   int rsp_hold_cycles;
   int rsp_stall_left;

   audio_wavefolder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Round half up: floor((v + 2^(s-1)) / 2^s), arithmetic shift gives the floor.
   function automatic longint round_shift(input longint v, input int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // sin(pi/2 * q / QUARTER) with FRAC_BITS fraction bits, Q30 Taylor series of degree 17
   function automatic longint quarter_wave(input longint unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          val;
      x    = (QUARTER_TURN_Q30 * q + QUARTER / 2) / QUARTER;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) sum -= $signed(term);
         else            sum += $signed(term);
      end
      if (sum < 0) sum = 0;
      val = round_shift(sum, 30 - FRAC_BITS);
      if (val > SAMPLE_MAX) val = SAMPLE_MAX;
      return val;
   endfunction

   // Build the full-cycle table by quarter-wave symmetry; the last entry wraps to the first.
   function automatic void build_sine_lut();
      longint unsigned wrapped;
      longint unsigned quad;
      longint unsigned r;
      longint          v;
      for (int k = 0; k <= LUT_SIZE; k++) begin
         wrapped = k & (LUT_SIZE - 1);
         quad    = wrapped / QUARTER;
         r       = wrapped % QUARTER;
         v       = quarter_wave(quad[0] ? QUARTER - r : r);
         sine_lut[k] = quad[1] ? -v : v;
      end
   endfunction

   // Expected output for one sample under the current shadow registers.
   function automatic logic signed [SAMPLE_BITS-1:0] fold_sample(
      input logic signed [SAMPLE_BITS-1:0] sample);
      longint x;
      longint g;
      longint w;
      longint ramp;
      longint span;
      longint phase;
      longint idx;
      longint frac;
      longint wm;
      longint mixed;
      longint scaled;
      if (cfg_enable == 0) return sample;
      x = sample;
      g = round_shift(x * cfg_in_gain, GAIN_FRAC);
      if (cfg_fold == FOLD_TRIANGLE) begin
         ramp = (g * cfg_tri_drive + TRI_BIAS) & (TRI_PERIOD - 1);
         span = (ramp < TRI_PERIOD - ramp) ? ramp : TRI_PERIOD - ramp;
         w    = round_shift(span - TRI_BIAS, GAIN_FRAC);
      end else begin
         phase = (g * cfg_sine_drive) & ((64'sd1 <<< PHASE_BITS) - 1);
         idx   = (phase >> LUT_LOW) & (LUT_SIZE - 1);
         frac  = (phase & ((64'sd1 <<< LUT_LOW) - 1)) >> INTERP_SHIFT;
         w     = sine_lut[idx];
         if (INTERP_BITS != 0)
            w += round_shift((sine_lut[idx + 1] - sine_lut[idx]) * frac, INTERP_BITS);
      end
      wm     = (cfg_wet > WET_UNITY) ? WET_UNITY : cfg_wet;
      mixed  = round_shift(w * wm + g * (WET_UNITY - wm), GAIN_FRAC);
      scaled = round_shift(mixed * cfg_out_gain, GAIN_FRAC);
      if (scaled > SAMPLE_MAX)      scaled = SAMPLE_MAX;
      else if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
      return scaled[SAMPLE_BITS-1:0];
   endfunction

   // Offer one register write, hold it until the transfer, then mirror it in the shadow.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         REG_ENABLE:         cfg_enable     = data & 16'h0001;
         REG_FOLD_TYPE:      cfg_fold       = data & 16'h0001;
         REG_SINE_DRIVE:     cfg_sine_drive = data;
         REG_TRIANGLE_DRIVE: cfg_tri_drive  = data;
         REG_INPUT_GAIN:     cfg_in_gain    = data;
         REG_OUTPUT_GAIN:    cfg_out_gain   = data;
         REG_WET_MIX:        cfg_wet        = data & 16'h1FFF;
         default: ;
      endcase
      // step off this edge so the next write never lands in the same time step
      @(posedge clock);
   endtask

   // Offer one sample. Called at a clock edge; valid stays high from the previous
   // transfer unless a random gap drops it first. Record the expectation on transfer.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      folded_sample_type entry;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      do @(posedge clock); while (req_ready !== 1'b1);
      entry.sample_in  = sample;
      entry.sample_out = fold_sample(sample);
      pending_samples.push_back(entry);
   endtask

   // Drop valid at the edge of the last transfer and step past that edge.
   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_results_done();
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2:    return SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_UNITY;
         3, 4:    return CSR_DATA_BITS'($urandom_range(1024, 12288));
         default: return CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   // Pick a fresh setting for every register; upper data bits carry noise that must drop.
   task automatic randomise_config();
      logic [CSR_DATA_BITS-1:0] noise;
      logic [MIX_BITS-1:0]      wet;
      noise = CSR_DATA_BITS'($urandom);
      write_reg(REG_ENABLE, {noise[15:1], 1'($urandom_range(0, 3) != 0)});
      noise = CSR_DATA_BITS'($urandom);
      write_reg(REG_FOLD_TYPE, {noise[15:1], 1'($urandom_range(0, 1))});
      write_reg(REG_SINE_DRIVE, random_gain());
      write_reg(REG_TRIANGLE_DRIVE, random_gain());
      write_reg(REG_INPUT_GAIN, random_gain());
      write_reg(REG_OUTPUT_GAIN, random_gain());
      case ($urandom_range(0, 5))
         0:       wet = '0;
         1:       wet = WET_FULL;
         2:       wet = MIX_BITS'($urandom_range(4097, 8191));
         default: wet = MIX_BITS'($urandom_range(0, 4096));
      endcase
      noise = CSR_DATA_BITS'($urandom);
      write_reg(REG_WET_MIX, {noise[15:13], wet});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, CSR_DATA_BITS'($urandom));
   endtask

   // Bypass straight after reset: the sample passes unchanged.
   task automatic test_passthrough();
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample('1);
      send_sample(24'sh555555);
      send_sample(24'shAAAAAA);
      stop_sending();
      wait_results_done();
   endtask

   // Enable only: everything else keeps its reset value (sine, unity, fully wet).
   task automatic test_reset_defaults();
      write_reg(REG_ENABLE, 16'd1);
      send_sample('0);
      send_sample(24'sh200000);
      send_sample(24'sh400000);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      stop_sending();
      wait_results_done();
   endtask

   // Triangle tie: the fold lands exactly half a period off, and the peak reaches
   // +full scale before the output saturates it.
   task automatic test_triangle_tie();
      write_reg(REG_FOLD_TYPE, FOLD_TRIANGLE);
      write_reg(REG_INPUT_GAIN, 16'd8192);
      send_sample(24'sh400000);
      send_sample(-24'sh400000);
      stop_sending();
      wait_results_done();
   endtask

   // Largest gains and drives on both fold shapes, then zero input and output gains on the sine fold.
   task automatic test_gain_extremes();
      write_reg(REG_INPUT_GAIN, '1);
      write_reg(REG_OUTPUT_GAIN, '1);
      write_reg(REG_SINE_DRIVE, '1);
      write_reg(REG_TRIANGLE_DRIVE, '1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      stop_sending();
      wait_results_done();
      write_reg(REG_FOLD_TYPE, FOLD_SINE);
      send_sample(24'sh003039);
      stop_sending();
      wait_results_done();
      write_reg(REG_INPUT_GAIN, '0);
      send_sample(SAMPLE_MAX);
      stop_sending();
      wait_results_done();
      write_reg(REG_INPUT_GAIN, GAIN_UNITY);
      write_reg(REG_OUTPUT_GAIN, '0);
      send_sample(SAMPLE_MIN);
      stop_sending();
      wait_results_done();
   endtask

   // Wet mix above full acts as full; also fully dry and half wet.
   task automatic test_wet_mix_clamp();
      write_reg(REG_OUTPUT_GAIN, GAIN_UNITY);
      write_reg(REG_SINE_DRIVE, GAIN_UNITY);
      write_reg(REG_WET_MIX, '1);
      send_sample(24'sh100000);
      stop_sending();
      wait_results_done();
      write_reg(REG_WET_MIX, '0);
      send_sample(24'sh100000);
      stop_sending();
      wait_results_done();
      write_reg(REG_WET_MIX, 16'd2048);
      send_sample(24'sh100000);
      stop_sending();
      wait_results_done();
   endtask

   // Bits above a register's width drop; a write to an unused index does nothing.
   task automatic test_register_masking();
      write_reg(REG_UNMAPPED, '1);
      write_reg(REG_ENABLE, 16'hFFFE);
      send_sample(24'sh123456);
      stop_sending();
      wait_results_done();
      write_reg(REG_ENABLE, 16'hFFFF);
      write_reg(REG_FOLD_TYPE, 16'hFFFF);
      send_sample(24'sh123456);
      stop_sending();
      wait_results_done();
   endtask

   // Hold the receiver off for a long stretch while samples keep coming, so the
   // pipe fills and stalls its input; then pause the sender until all results are in.
   task automatic test_backpressure();
      write_reg(REG_ENABLE, 16'd1);
      write_reg(REG_FOLD_TYPE, FOLD_SINE);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      rsp_hold_cycles  = 100;
      repeat (50) send_sample(random_sample());
      stop_sending();
      wait_results_done();
   endtask

   // Bursts of random samples, each under a fresh register setting.
   task automatic test_random_phases(input int item_target, input bit with_idling);
      int sent;
      int burst;
      sent = 0;
      while (sent < item_target) begin
         randomise_config();
         sender_idle_on   = with_idling && ($urandom_range(0, 3) != 0);
         receiver_idle_on = with_idling && ($urandom_range(0, 3) != 0);
         burst = $urandom_range(10, 40);
         repeat (burst) send_sample(random_sample());
         sent += burst;
         stop_sending();
         wait_results_done();
      end
   endtask

   // Receiver side: a long hold-off when asked, else random stall bursts when idling is on.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Check each result transfer against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_samples.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     rsp_sample_out);
         end else begin
            oldest = pending_samples.pop_front();
            if (rsp_sample_out !== oldest.sample_out) begin
               error_count++;
               $display("%0t: sample_out for input %h: expected %h, actual %h", $time,
                        oldest.sample_in, oldest.sample_out, rsp_sample_out);
            end
         end
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_data      <= '0;
      error_count      = 0;
      rsp_hold_cycles  = 0;
      rsp_stall_left   = 0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      cfg_enable     = 0;
      cfg_fold       = FOLD_SINE;
      cfg_sine_drive = GAIN_ONE;
      cfg_tri_drive  = GAIN_ONE;
      cfg_in_gain    = GAIN_ONE;
      cfg_out_gain   = GAIN_ONE;
      cfg_wet        = WET_UNITY;
      build_sine_lut();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_passthrough();
      test_reset_defaults();
      test_triangle_tie();
      test_gain_extremes();
      test_wet_mix_clamp();
      test_register_masking();
      test_random_phases(300, 1'b1);
      test_backpressure();
      test_random_phases(200, 1'b1);
      // closing stretch runs flat out on both sides
      test_random_phases(60, 1'b0);

      wait_results_done();
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
